@@ rtl/ihb_pkg.sv @@
// ihb_pkg: shared types and constants for the ipv4 header builder
// no dependencies; imported by every module of the block
package ihb_pkg;

  // header layout
  localparam int unsigned HDR_WORDS  = 5;
  localparam int unsigned HDR_BYTES  = 20;
  localparam logic [3:0]  IP_VERSION = 4'd4;
  localparam logic [3:0]  IP_IHL     = 4'(HDR_BYTES / 4);
  localparam logic [15:0] DF_BIT     = 16'h4000;

  // result word position
  localparam int unsigned WORD_IDX_W    = 3;
  localparam logic [WORD_IDX_W-1:0] FIRST_WORD_IDX = WORD_IDX_W'(0);
  localparam logic [WORD_IDX_W-1:0] LAST_WORD_IDX  = WORD_IDX_W'(HDR_WORDS - 1);

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TTL = 2'd0,
    REG_DF  = 2'd1,
    REG_TOS = 2'd2
  } cfg_reg_t;

  // register reset values
  localparam logic [7:0] DEFAULT_TTL = 8'd64;
  localparam logic       DEFAULT_DF  = 1'b1;
  localparam logic [7:0] DEFAULT_TOS = 8'd0;

  // queue between builder and serializer
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] ttl;
    logic       df;
    logic [7:0] tos;
  } cfg_t;

  // one finished header
  typedef struct packed {
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] w3;
    logic [31:0] w4;
    logic        err;
  } hdr_t;

  // queue status toward both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ rtl/ipv4_header_build.sv @@
// ipv4_header_build: ipv4 header builder with header checksum
// request channel in, one 32-bit header word per result item out
// a request of protocol, identification, addresses and payload length yields
// five big-endian header words, word_index 0 to 4, last_word on word 4 and
// length_error on all five when 20 plus payload length exceeds 65535
// an item is taken at a clock edge with valid high and stall low, on both sides
// cfg_we writes cfg_data into register cfg_index: 0 ttl, 1 dont_fragment,
// 2 type_of_service; other indexes are ignored
// word 0 passes through the builder stage, the header queue and the output
// register; the other words follow one per cycle while the receiver does not stall
// the single 32-bit output register sends one header word at a time; the builder
// keeps taking requests while a header is serialized
// a request waits in the builder stage when the header queue is full, and
// then in_stall is high; out_stall holds the current word in place
// reset (rst_n low, synchronous) empties stage, queue and output and returns
// the registers to ttl 64, dont_fragment 1, type_of_service 0
// depends on ihb_pkg, ihb_front, ihb_queue, ihb_back
module ipv4_header_build #(
  parameter int unsigned QUEUE_DEPTH = ihb_pkg::QUEUE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_protocol_number,
  input  logic [15:0]                        in_identification,
  input  logic [31:0]                        in_source_address,
  input  logic [31:0]                        in_destination_address,
  input  logic [15:0]                        in_payload_length,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [31:0]                        out_header_word,
  output logic [ihb_pkg::WORD_IDX_W-1:0]     out_word_index,
  output logic                               out_last_word,
  output logic                               out_length_error,
  input  logic                               cfg_we,
  input  logic [ihb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ihb_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ihb_pkg::*;

  cfg_t    cfg_r, cfg_nxt;
  q_stat_t q_stat;
  hdr_t    push_data;
  hdr_t    pop_data;
  logic    push;
  logic    pop;

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_TTL: cfg_nxt.ttl = cfg_data[7:0];
        REG_DF:  cfg_nxt.df  = cfg_data[0];
        REG_TOS: cfg_nxt.tos = cfg_data[7:0];
        default: cfg_nxt     = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ttl <= DEFAULT_TTL;
      cfg_r.df  <= DEFAULT_DF;
      cfg_r.tos <= DEFAULT_TOS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // header builder
  ihb_front u_front (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_protocol_number     (in_protocol_number),
    .in_identification      (in_identification),
    .in_source_address      (in_source_address),
    .in_destination_address (in_destination_address),
    .in_payload_length      (in_payload_length),
    .cfg                    (cfg_r),
    .q_stat                 (q_stat),
    .push                   (push),
    .push_data              (push_data)
  );

  // header queue
  ihb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  // word serializer
  ihb_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_stat           (q_stat),
    .pop_data         (pop_data),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_header_word  (out_header_word),
    .out_word_index   (out_word_index),
    .out_last_word    (out_last_word),
    .out_length_error (out_length_error)
  );

`ifndef SYNTHESIS
  // queue is never written while full nor read while empty
  a_queue_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_stat.full) && !(pop && q_stat.empty))
    else $error("header queue overflow or underflow");

  // last_word flags exactly the final word position
  a_last_matches_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == LAST_WORD_IDX)))
    else $error("last_word does not match word_index");

  // word 0 always carries version and header length
  a_word0_version: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_word_index == FIRST_WORD_IDX)) |->
      (out_header_word[31:24] == {IP_VERSION, IP_IHL}))
    else $error("word 0 lacks version and header length");

  // a word taken that is not the last is followed by the next position
  a_index_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_word && $past(out_valid) && !$past(out_stall))
      |-> (out_word_index == $past(out_word_index) + 1'b1) ||
          ($past(out_last_word)))
    else $error("word index skipped a position");
`endif

endmodule

@@ rtl/ihb_front.sv @@
// ihb_front: accepts requests, forms the header words and the checksum
// depends on ihb_pkg; pushes finished headers into ihb_queue
module ihb_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_protocol_number,
  input  logic [15:0]      in_identification,
  input  logic [31:0]      in_source_address,
  input  logic [31:0]      in_destination_address,
  input  logic [15:0]      in_payload_length,
  input  ihb_pkg::cfg_t    cfg,
  input  ihb_pkg::q_stat_t q_stat,
  output logic             push,
  output ihb_pkg::hdr_t    push_data
);
  import ihb_pkg::*;

  logic        s_valid_r, s_valid_nxt;
  logic [31:0] w0_r, w1_r, w2_r, w3_r, w4_r;
  logic [19:0] sum_r;
  logic        err_r;

  logic        accept;
  logic [16:0] total;
  logic [15:0] flag_hw;
  logic [31:0] w0_nxt, w1_nxt, w2_nxt;
  logic [19:0] sum_nxt;
  logic [16:0] fold1;
  logic [15:0] fold2;

  // handshake: hold the request until the queue has room
  assign push     = s_valid_r && !q_stat.full;
  assign in_stall = s_valid_r && q_stat.full;
  assign accept   = in_valid && !in_stall;

  // header words before the checksum is inserted
  always_comb begin
    total   = 17'(HDR_BYTES) + {1'b0, in_payload_length};
    flag_hw = cfg.df ? DF_BIT : 16'h0000;
    w0_nxt  = {IP_VERSION, IP_IHL, cfg.tos, total[15:0]};
    w1_nxt  = {in_identification, flag_hw};
    w2_nxt  = {cfg.ttl, in_protocol_number, 16'h0000};
  end

  // sum of the ten halfwords, checksum field at zero
  always_comb begin
    sum_nxt = 20'(w0_nxt[31:16]) + 20'(w0_nxt[15:0])
            + 20'(w1_nxt[31:16]) + 20'(w1_nxt[15:0])
            + 20'(w2_nxt[31:16])
            + 20'(in_source_address[31:16]) + 20'(in_source_address[15:0])
            + 20'(in_destination_address[31:16])
            + 20'(in_destination_address[15:0]);
  end

  // stage valid
  always_comb begin
    s_valid_nxt = s_valid_r;
    if (accept) begin
      s_valid_nxt = 1'b1;
    end else if (push) begin
      s_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else begin
      s_valid_r <= s_valid_nxt;
    end
  end

  // request payload
  always_ff @(posedge clk) begin
    if (accept) begin
      w0_r  <= w0_nxt;
      w1_r  <= w1_nxt;
      w2_r  <= w2_nxt;
      w3_r  <= in_source_address;
      w4_r  <= in_destination_address;
      sum_r <= sum_nxt;
      err_r <= total[16];
    end
  end

  // end-around carry fold, two passes cover a 20-bit sum
  always_comb begin
    fold1 = 17'(sum_r[15:0]) + 17'(sum_r[19:16]);
    fold2 = fold1[15:0] + 16'(fold1[16]);
  end

  always_comb begin
    push_data.w0  = w0_r;
    push_data.w1  = w1_r;
    push_data.w2  = {w2_r[31:16], ~fold2};
    push_data.w3  = w3_r;
    push_data.w4  = w4_r;
    push_data.err = err_r;
  end

endmodule

@@ rtl/ihb_queue.sv @@
// ihb_queue: short header queue between the builder and the serializer
// depends on ihb_pkg; depth set by the DEPTH parameter (at least 2)
module ihb_queue #(
  parameter int unsigned DEPTH = ihb_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ihb_pkg::hdr_t    push_data,
  input  logic             pop,
  output ihb_pkg::hdr_t    pop_data,
  output ihb_pkg::q_stat_t q_stat
);
  import ihb_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  hdr_t             entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data     = entry_r[rd_ptr_r];
  assign q_stat.full  = (count_r == CNT_W'(DEPTH));
  assign q_stat.empty = (count_r == '0);

endmodule

@@ rtl/ihb_back.sv @@
// ihb_back: serializes the queued header into five output words
// depends on ihb_pkg; pops ihb_queue when the last word is loaded
module ihb_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ihb_pkg::q_stat_t                   q_stat,
  input  ihb_pkg::hdr_t                      pop_data,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [31:0]                        out_header_word,
  output logic [ihb_pkg::WORD_IDX_W-1:0]     out_word_index,
  output logic                               out_last_word,
  output logic                               out_length_error
);
  import ihb_pkg::*;

  logic                  valid_r, valid_nxt;
  logic [WORD_IDX_W-1:0] idx_r, idx_nxt;
  logic [31:0]           word_r;
  logic [WORD_IDX_W-1:0] word_idx_r;
  logic                  last_r;
  logic                  err_r;

  logic                  load;
  logic                  at_last;
  logic [31:0]           word_sel;

  // output register is free when empty or being taken
  assign load    = !q_stat.empty && (!valid_r || !out_stall);
  assign at_last = (idx_r == LAST_WORD_IDX);
  assign pop     = load && at_last;

  // pick the current header word
  always_comb begin
    case (idx_r)
      3'd0:    word_sel = pop_data.w0;
      3'd1:    word_sel = pop_data.w1;
      3'd2:    word_sel = pop_data.w2;
      3'd3:    word_sel = pop_data.w3;
      default: word_sel = pop_data.w4;
    endcase
  end

  // word counter and output valid
  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      idx_nxt   = at_last ? FIRST_WORD_IDX : idx_r + 1'b1;
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= FIRST_WORD_IDX;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      word_r     <= word_sel;
      word_idx_r <= idx_r;
      last_r     <= at_last;
      err_r      <= pop_data.err;
    end
  end

  assign out_valid        = valid_r;
  assign out_header_word  = word_r;
  assign out_word_index   = word_idx_r;
  assign out_last_word    = last_r;
  assign out_length_error = err_r;

endmodule
